FILE: rtl/hrds_pkg.sv
// Shared types, codes and arithmetic constants for the HSV/RGB LED duty setter.
`timescale 1ns / 1ps

package hrds_pkg;

  // Command queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_RGB = 1'b0,
    OP_HSV = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SEL_BOTH   = 2'd0,
    SEL_FIRST  = 2'd1,
    SEL_SECOND = 2'd2,
    SEL_NONE   = 2'd3
  } sel_t;

  // Hue sextants of 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Range limits
  localparam logic [8:0] RGB_MAX = 9'd255;
  localparam logic [8:0] HUE_MAX = 9'd359;
  localparam logic [7:0] PCT_MAX = 8'd100;

  // Percent scale and sextant span for the conversion
  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [5:0] FRAC_SPAN = 6'd60;

  // top = vp / 100 with vp < 2^15
  localparam logic [14:0] TOP_DIV   = 15'd100;
  localparam logic [8:0]  TOP_RECIP = 9'd327;
  localparam int          TOP_SHIFT = 15;

  // low = prod / 10000 with prod < 2^22
  localparam logic [21:0] LOW_DIV   = 22'd10000;
  localparam logic [8:0]  LOW_RECIP = 9'd419;
  localparam int          LOW_SHIFT = 22;

  // fall and rise steps: prod / 600000 with prod < 2^28
  localparam logic [27:0] EDGE_DIV   = 28'd600000;
  localparam logic [8:0]  EDGE_RECIP = 9'd447;
  localparam int          EDGE_SHIFT = 28;

  // One queued command, already checked and split up
  typedef struct packed {
    logic        bad;
    logic        hsv;
    sel_t        sel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    sector_t     sector;
    logic [5:0]  frac;
    logic [6:0]  sat;
    logic [14:0] vp;
  } hrds_item_t;

  // First hue degree of each sextant
  function automatic logic [8:0] sector_base(sector_t sec);
    logic [8:0] base;
    unique case (sec)
      SEC_RED:     base = 9'd0;
      SEC_YELLOW:  base = 9'd60;
      SEC_GREEN:   base = 9'd120;
      SEC_CYAN:    base = 9'd180;
      SEC_BLUE:    base = 9'd240;
      SEC_MAGENTA: base = 9'd300;
      default:     base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

FILE: rtl/hrds_cmd_if.sv
// Command channel: mode, LED select and three values with valid/ready.
`timescale 1ns / 1ps

interface hrds_cmd_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] led_select;
  logic [8:0] first_value;
  logic [7:0] second_value;
  logic [7:0] third_value;

  modport source (
    output valid, operation, led_select, first_value, second_value, third_value,
    input  ready
  );

  modport sink (
    input  valid, operation, led_select, first_value, second_value, third_value,
    output ready
  );
endinterface

FILE: rtl/hrds_duty_if.sv
// Result channel: six LED duties and the range error flag with valid/ready.
`timescale 1ns / 1ps

interface hrds_duty_if;
  logic       valid;
  logic       ready;
  logic [7:0] led1_red;
  logic [7:0] led1_green;
  logic [7:0] led1_blue;
  logic [7:0] led2_red;
  logic [7:0] led2_green;
  logic [7:0] led2_blue;
  logic       range_error;

  modport source (
    output valid, led1_red, led1_green, led1_blue, led2_red, led2_green, led2_blue,
    output range_error,
    input  ready
  );

  modport sink (
    input  valid, led1_red, led1_green, led1_blue, led2_red, led2_green, led2_blue,
    input  range_error,
    output ready
  );
endinterface

FILE: rtl/hrds_front.sv
// Front part: range check, hue sextant split and value scaling of each command.
`timescale 1ns / 1ps

module hrds_front import hrds_pkg::*; (
  hrds_cmd_if.sink   cmd,
  output logic       push_valid,
  input  logic       push_ready,
  output hrds_item_t push_item
);

  logic       rgb_bad;
  logic       hsv_bad;
  sector_t    sector;
  logic [8:0] frac_full;

  // Pass the handshake straight to the queue
  assign push_valid = cmd.valid;
  assign cmd.ready  = push_ready;

  // Check ranges and find the sextant
  always_comb begin
    rgb_bad = cmd.first_value > RGB_MAX;
    hsv_bad = (cmd.first_value > HUE_MAX) || (cmd.second_value > PCT_MAX) ||
              (cmd.third_value > PCT_MAX);

    priority if (cmd.first_value < sector_base(SEC_YELLOW)) sector = SEC_RED;
    else if (cmd.first_value < sector_base(SEC_GREEN))      sector = SEC_YELLOW;
    else if (cmd.first_value < sector_base(SEC_CYAN))       sector = SEC_GREEN;
    else if (cmd.first_value < sector_base(SEC_BLUE))       sector = SEC_CYAN;
    else if (cmd.first_value < sector_base(SEC_MAGENTA))    sector = SEC_BLUE;
    else                                                    sector = SEC_MAGENTA;

    frac_full = cmd.first_value - sector_base(sector);
  end

  // Build the queue entry; vp is value times 255
  always_comb begin
    push_item.hsv    = (op_t'(cmd.operation) == OP_HSV);
    push_item.bad    = push_item.hsv ? hsv_bad : rgb_bad;
    push_item.sel    = sel_t'(cmd.led_select);
    push_item.red    = cmd.first_value[7:0];
    push_item.green  = cmd.second_value;
    push_item.blue   = cmd.third_value;
    push_item.sector = sector;
    push_item.frac   = frac_full[5:0];
    push_item.sat    = cmd.second_value[6:0];
    push_item.vp     = {cmd.third_value[6:0], 8'h00} - {8'h00, cmd.third_value[6:0]};
  end

endmodule

FILE: rtl/hrds_queue.sv
// Short command queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module hrds_queue import hrds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  hrds_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output hrds_item_t pop_item
);

  hrds_item_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push_fire;
  logic                pop_fire;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/hrds_back.sv
// Back part: HSV conversion sequencer, duty registers and result register.
`timescale 1ns / 1ps

module hrds_back import hrds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  hrds_item_t  pop_item,
  hrds_duty_if.source duty
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIX,
    S_WRITE
  } state_t;

  state_t     state;
  hrds_item_t item;
  logic       out_valid;
  logic       err;

  logic [7:0] led1_red, led1_green, led1_blue;
  logic [7:0] led2_red, led2_green, led2_blue;

  // Conversion datapath registers
  logic [21:0] low_prod;
  logic [21:0] sat_prod;
  logic [27:0] fall_prod;
  logic [27:0] rise_prod;
  logic [7:0]  top_est, top_val;
  logic [7:0]  low_est, low_val;
  logic [7:0]  fall_est, fall_q;
  logic [7:0]  rise_est, rise_q;

  // Combinational products and corrections
  logic [23:0] top_mul;
  logic [14:0] top_rem;
  logic [30:0] low_mul;
  logic [21:0] low_rem;
  logic [36:0] fall_mul;
  logic [36:0] rise_mul;
  logic [27:0] fall_rem;
  logic [27:0] rise_rem;
  logic [7:0]  fall_val, rise_val;
  logic [7:0]  new_red, new_green, new_blue;
  logic        out_free;

  always_comb begin
    top_mul  = 24'(item.vp) * 24'(TOP_RECIP);
    top_rem  = item.vp - 15'(top_est) * TOP_DIV;
    low_mul  = 31'(low_prod) * 31'(LOW_RECIP);
    low_rem  = low_prod - 22'(low_est) * LOW_DIV;
    fall_mul = 37'(fall_prod) * 37'(EDGE_RECIP);
    rise_mul = 37'(rise_prod) * 37'(EDGE_RECIP);
    fall_rem = fall_prod - 28'(fall_est) * EDGE_DIV;
    rise_rem = rise_prod - 28'(rise_est) * EDGE_DIV;
  end

  // Pick colors by sextant, or pass direct values
  always_comb begin
    fall_val  = top_val - fall_q;
    rise_val  = top_val - rise_q;
    new_red   = item.red;
    new_green = item.green;
    new_blue  = item.blue;
    if (item.hsv) begin
      unique case (item.sector)
        SEC_RED:     begin new_red = top_val;  new_green = rise_val; new_blue = low_val;  end
        SEC_YELLOW:  begin new_red = fall_val; new_green = top_val;  new_blue = low_val;  end
        SEC_GREEN:   begin new_red = low_val;  new_green = top_val;  new_blue = rise_val; end
        SEC_CYAN:    begin new_red = low_val;  new_green = fall_val; new_blue = top_val;  end
        SEC_BLUE:    begin new_red = rise_val; new_green = low_val;  new_blue = top_val;  end
        default:     begin new_red = top_val;  new_green = low_val;  new_blue = fall_val; end
      endcase
    end
  end

  assign pop_ready = (state == S_IDLE);
  assign out_free  = !out_valid || duty.ready;

  assign duty.valid       = out_valid;
  assign duty.led1_red    = led1_red;
  assign duty.led1_green  = led1_green;
  assign duty.led1_blue   = led1_blue;
  assign duty.led2_red    = led2_red;
  assign duty.led2_green  = led2_green;
  assign duty.led2_blue   = led2_blue;
  assign duty.range_error = err;

  // Sequence one command at a time through the shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      led1_red   <= '0;
      led1_green <= '0;
      led1_blue  <= '0;
      led2_red   <= '0;
      led2_green <= '0;
      led2_blue  <= '0;
    end else begin
      // Drop the result once it is taken, unless the write step replaces it
      if (out_valid && duty.ready && state != S_WRITE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            item  <= pop_item;
            state <= (pop_item.hsv && !pop_item.bad) ? S_MUL1 : S_WRITE;
          end
        end

        // Scaled products and the top estimate
        S_MUL1: begin
          low_prod <= 22'(item.vp) * 22'(PCT_SCALE - item.sat);
          sat_prod <= 22'(item.vp) * 22'(item.sat);
          top_est  <= top_mul[TOP_SHIFT + 7:TOP_SHIFT];
          state    <= S_MUL2;
        end

        // Hue-weighted products, fix top, estimate low
        S_MUL2: begin
          fall_prod <= 28'(sat_prod) * 28'(item.frac);
          rise_prod <= 28'(sat_prod) * 28'(FRAC_SPAN - item.frac);
          top_val   <= top_est + 8'(top_rem >= TOP_DIV);
          low_est   <= low_mul[LOW_SHIFT + 7:LOW_SHIFT];
          state     <= S_MUL3;
        end

        // Estimate edge steps, fix low
        S_MUL3: begin
          fall_est <= fall_mul[EDGE_SHIFT + 7:EDGE_SHIFT];
          rise_est <= rise_mul[EDGE_SHIFT + 7:EDGE_SHIFT];
          low_val  <= low_est + 8'(low_rem >= LOW_DIV);
          state    <= S_FIX;
        end

        // Fix edge steps
        S_FIX: begin
          fall_q <= fall_est + 8'(fall_rem >= EDGE_DIV);
          rise_q <= rise_est + 8'(rise_rem >= EDGE_DIV);
          state  <= S_WRITE;
        end

        // Update duties and present the result once the output is free
        S_WRITE: begin
          if (out_free) begin
            if (!item.bad) begin
              if (item.sel == SEL_BOTH || item.sel == SEL_FIRST) begin
                led1_red   <= new_red;
                led1_green <= new_green;
                led1_blue  <= new_blue;
              end
              if (item.sel == SEL_BOTH || item.sel == SEL_SECOND) begin
                led2_red   <= new_red;
                led2_green <= new_green;
                led2_blue  <= new_blue;
              end
            end
            err       <= item.bad;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hsv_rgb_led_duty_setter.sv
// Top level of the HSV/RGB LED duty setter.
//
// Usage:
//   cmd  (sink)   takes one command per transaction: mode, LED select and
//                 three values (RGB 0-255, or hue 0-359 / sat 0-100 / val 0-100).
//   duty (source) returns one transaction per command with all six duties
//                 after the command and a range error flag.
// An HSV command passes the back sequencer states MUL1, MUL2, MUL3, FIX and
// WRITE before its result is valid; a direct RGB or rejected command goes
// straight to WRITE. The sequencer takes a new command only once the last one
// is written, and runs the conversion on one shared multiply/correct datapath
// (three multiply steps and one fix step).
// A two-entry queue sits between the command checker and the sequencer, so
// commands are still taken while a result waits on the duty channel.
// Reset clears all duties to zero (both LEDs off), empties the queue and
// drops any pending result. When the receiver stalls, the result holds and
// the sequencer waits; the queue then fills and cmd.ready falls.
`timescale 1ns / 1ps

module hsv_rgb_led_duty_setter import hrds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hrds_cmd_if.sink    cmd,
  hrds_duty_if.source duty
);

  logic       push_valid;
  logic       push_ready;
  hrds_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  hrds_item_t pop_item;

  hrds_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hrds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hrds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .duty      (duty)
  );

endmodule

FILE: rtl/hrds_checker.sv
// Port-level checker for the LED duty setter, bound to the top level.
`timescale 1ns / 1ps

module hrds_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] led1_red,
  input logic [7:0] led1_green,
  input logic [7:0] led1_blue,
  input logic [7:0] led2_red,
  input logic [7:0] led2_green,
  input logic [7:0] led2_blue,
  input logic       range_error
);

  logic [2:0] pending;
  logic [7:0] last_l1r, last_l1g, last_l1b;
  logic [7:0] last_l2r, last_l2g, last_l2b;
  logic       cmd_fire;
  logic       out_fire;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign out_fire = out_valid && out_ready;

  // Track commands in flight and the duties last delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      last_l1r <= '0;
      last_l1g <= '0;
      last_l1b <= '0;
      last_l2r <= '0;
      last_l2g <= '0;
      last_l2b <= '0;
    end else begin
      pending <= pending + 3'(cmd_fire) - 3'(out_fire);
      if (out_fire) begin
        last_l1r <= led1_red;
        last_l1g <= led1_green;
        last_l1b <= led1_blue;
        last_l2r <= led2_red;
        last_l2g <= led2_green;
        last_l2b <= led2_blue;
      end
    end
  end

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(led1_red) &&
      $stable(led1_green) && $stable(led1_blue) && $stable(led2_red) &&
      $stable(led2_green) && $stable(led2_blue) && $stable(range_error)))
    else $error("result changed while stalled");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A rejected command leaves every duty as last reported
  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_fire && range_error) |-> (led1_red == last_l1r && led1_green == last_l1g &&
      led1_blue == last_l1b && led2_red == last_l2r && led2_green == last_l2g &&
      led2_blue == last_l2b))
    else $error("rejected command changed a duty");

  // No result without an outstanding command
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 3'd0))
    else $error("result with no command in flight");

endmodule

bind hsv_rgb_led_duty_setter hrds_checker u_hrds_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .out_valid   (duty.valid),
  .out_ready   (duty.ready),
  .led1_red    (duty.led1_red),
  .led1_green  (duty.led1_green),
  .led1_blue   (duty.led1_blue),
  .led2_red    (duty.led2_red),
  .led2_green  (duty.led2_green),
  .led2_blue   (duty.led2_blue),
  .range_error (duty.range_error)
);
